>>> src/rle6_pkg.sv
// ----------------------------------------------------------------------------
// rle6_pkg
// Shared types, widths and the 6-to-8 bit alpha expansion table for the
// run-length alpha layer decoder.
// ----------------------------------------------------------------------------
package rle6_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned CNT_W   = 23;
  localparam int unsigned PIX_W   = 22;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned A6_W    = 6;

  // wide enough to compare any supported position against the pixel count
  localparam int unsigned CMP_W = 33;

  localparam logic [CNT_W-1:0]  PIXEL_COUNT_RESET = 23'h400000;
  localparam logic [A6_W-1:0]   ALPHA_MAX         = 6'h3F;
  localparam logic [BYTE_W-1:0] CTRL_MIN_NEG      = 8'h80;

  // one accepted input transaction
  typedef struct packed {
    logic                  layer_start;
    logic [BYTE_W-1:0]     data_byte;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic                  out_of_range;
    logic [ALPHA_W-1:0]    alpha_value;
    logic [PIX_W-1:0]      pixel_index;
  } result_t;

  // 6-bit to 8-bit alpha expansion
  function automatic logic [ALPHA_W-1:0] expand6(input logic [A6_W-1:0] idx);
    logic [ALPHA_W-1:0] v;
    case (idx)
      6'd0:  v = 8'd0;    6'd1:  v = 8'd4;    6'd2:  v = 8'd8;    6'd3:  v = 8'd12;
      6'd4:  v = 8'd16;   6'd5:  v = 8'd20;   6'd6:  v = 8'd24;   6'd7:  v = 8'd28;
      6'd8:  v = 8'd32;   6'd9:  v = 8'd36;   6'd10: v = 8'd40;   6'd11: v = 8'd44;
      6'd12: v = 8'd48;   6'd13: v = 8'd52;   6'd14: v = 8'd56;   6'd15: v = 8'd60;
      6'd16: v = 8'd64;   6'd17: v = 8'd68;   6'd18: v = 8'd72;   6'd19: v = 8'd76;
      6'd20: v = 8'd80;   6'd21: v = 8'd85;   6'd22: v = 8'd89;   6'd23: v = 8'd93;
      6'd24: v = 8'd97;   6'd25: v = 8'd101;  6'd26: v = 8'd105;  6'd27: v = 8'd109;
      6'd28: v = 8'd113;  6'd29: v = 8'd117;  6'd30: v = 8'd121;  6'd31: v = 8'd125;
      6'd32: v = 8'd129;  6'd33: v = 8'd133;  6'd34: v = 8'd137;  6'd35: v = 8'd141;
      6'd36: v = 8'd145;  6'd37: v = 8'd149;  6'd38: v = 8'd153;  6'd39: v = 8'd157;
      6'd40: v = 8'd161;  6'd41: v = 8'd165;  6'd42: v = 8'd170;  6'd43: v = 8'd174;
      6'd44: v = 8'd178;  6'd45: v = 8'd182;  6'd46: v = 8'd186;  6'd47: v = 8'd190;
      6'd48: v = 8'd194;  6'd49: v = 8'd198;  6'd50: v = 8'd202;  6'd51: v = 8'd206;
      6'd52: v = 8'd210;  6'd53: v = 8'd214;  6'd54: v = 8'd218;  6'd55: v = 8'd222;
      6'd56: v = 8'd226;  6'd57: v = 8'd230;  6'd58: v = 8'd234;  6'd59: v = 8'd238;
      6'd60: v = 8'd242;  6'd61: v = 8'd246;  6'd62: v = 8'd250;  6'd63: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/rle6_in_reg.sv
// ----------------------------------------------------------------------------
// rle6_in_reg
// Input register: holds one accepted transaction until the decoder takes it.
// ----------------------------------------------------------------------------
module rle6_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rle6_pkg::in_item_t in_item,
  output logic               hold_valid,
  output rle6_pkg::in_item_t hold_item,
  input  logic               take
);

  // free when empty or when the held item leaves this cycle
  assign in_ready = !hold_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

>>> src/rle6_decode.sv
// ----------------------------------------------------------------------------
// rle6_decode
// Run state, pixel position and pixel count register; decodes one byte per
// cycle (literals need a free output slot) to skip, run start or alpha write.
// ----------------------------------------------------------------------------
module rle6_decode #(
  parameter int unsigned INDEX_BITS = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rle6_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          item_valid,
  input  rle6_pkg::in_item_t            item,
  input  logic                          out_free,
  output logic                          take,
  output logic                          produce,
  output rle6_pkg::result_t             result
);

  logic [rle6_pkg::CNT_W-1:0] pixel_count;
  logic [rle6_pkg::RUN_W-1:0] literal_left;
  logic [rle6_pkg::RUN_W-1:0] literal_left_next;
  logic [INDEX_BITS-1:0]      position;
  logic [INDEX_BITS-1:0]      position_next;

  logic [rle6_pkg::RUN_W-1:0] cur_left;
  logic [INDEX_BITS-1:0]      cur_pos;
  logic [rle6_pkg::CMP_W-1:0] pos_wide;
  logic [rle6_pkg::A6_W-1:0]  alpha_sat;
  logic [rle6_pkg::BYTE_W-1:0] byte_in;
  logic                       is_literal;

  // layer start clears the run state before the byte is decoded
  assign byte_in    = item.data_byte;
  assign cur_left   = item.layer_start ? '0 : literal_left;
  assign cur_pos    = item.layer_start ? '0 : position;
  assign is_literal = (cur_left != '0);
  assign pos_wide   = rle6_pkg::CMP_W'(cur_pos);

  // a control byte never waits on the output side
  assign produce = item_valid && is_literal;
  assign take    = item_valid && (!is_literal || out_free);

  // alpha saturates at 63, then inverts and expands
  assign alpha_sat = (byte_in > rle6_pkg::BYTE_W'(rle6_pkg::ALPHA_MAX)) ?
                     rle6_pkg::ALPHA_MAX : byte_in[rle6_pkg::A6_W-1:0];

  // result fields
  always_comb begin
    result.pixel_index  = pos_wide[rle6_pkg::PIX_W-1:0];
    result.alpha_value  = rle6_pkg::expand6(~alpha_sat);
    result.out_of_range = (pos_wide >= rle6_pkg::CMP_W'(pixel_count));
  end

  // next run state and position
  always_comb begin
    literal_left_next = cur_left;
    position_next     = cur_pos;
    if (is_literal) begin
      literal_left_next = cur_left - 1'b1;
      position_next     = cur_pos + 1'b1;
    end else if (byte_in > rle6_pkg::CTRL_MIN_NEG) begin
      literal_left_next = byte_in[rle6_pkg::RUN_W-1:0];
    end else if (!byte_in[rle6_pkg::BYTE_W-1]) begin
      // skip; a zero byte adds nothing
      position_next = cur_pos + INDEX_BITS'(byte_in);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      literal_left <= '0;
      position     <= '0;
    end else if (take) begin
      literal_left <= literal_left_next;
      position     <= position_next;
    end
  end

  // pixel count register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= rle6_pkg::PIXEL_COUNT_RESET;
    end else if (cfg_we) begin
      pixel_count <= cfg_wdata;
    end
  end

endmodule

>>> src/rle6_out_reg.sv
// ----------------------------------------------------------------------------
// rle6_out_reg
// Result register: holds one alpha write until the downstream side takes it.
// ----------------------------------------------------------------------------
module rle6_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rle6_pkg::result_t load_result,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output rle6_pkg::result_t out_result
);

  // slot is free when empty or being drained
  assign out_free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_result <= load_result;
    end
  end

endmodule

>>> src/rle_alpha6_layer_decoder.sv
// ----------------------------------------------------------------------------
// rle_alpha6_layer_decoder
// Run-length alpha layer decoder: control bytes skip pixels or open a
// literal run; each literal byte becomes an expanded alpha write.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[7:0] data_byte, tuser layer_start
//  m_axis    out  tvalid/tready           tdata[21:0] pixel_index,
//                                         tdata[29:22] alpha_value, tuser out_of_range
//  cfg       in   cfg_we                  cfg_wdata pixel_count
//
//  one byte per cycle sustained while m_axis is not stalled; a literal byte
//  reaches m_axis through the input register, then the result register
//  control bytes retire without using the result register
//  rst is synchronous; clears run state, position, valids, pixel_count=2^22
//  a stalled m_axis holds only literal bytes back; s_axis_tready follows
// ----------------------------------------------------------------------------
module rle_alpha6_layer_decoder #(
  parameter int unsigned INDEX_BITS = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] layer_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [21:0] pixel_index, [29:22] alpha_value
  output logic        m_axis_tuser,   // [0] out_of_range
  input  logic        cfg_we,
  input  logic [22:0] cfg_wdata       // [22:0] pixel_count
);

  rle6_pkg::in_item_t in_item;
  rle6_pkg::in_item_t hold_item;
  rle6_pkg::result_t  dec_result;
  rle6_pkg::result_t  out_result;
  logic               hold_valid;
  logic               take;
  logic               produce;
  logic               out_free;

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.layer_start = s_axis_tuser;

  // input register
  rle6_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  // decoder and run state
  rle6_decode #(
    .INDEX_BITS (INDEX_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (hold_valid),
    .item       (hold_item),
    .out_free   (out_free),
    .take       (take),
    .produce    (produce),
    .result     (dec_result)
  );

  // result register
  rle6_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (produce),
    .load_result (dec_result),
    .out_free    (out_free),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (out_result)
  );

  // output packing
  assign m_axis_tdata = {2'b00, out_result.alpha_value, out_result.pixel_index};
  assign m_axis_tuser = out_result.out_of_range;

endmodule

>>> src/rle6_checker.sv
// ----------------------------------------------------------------------------
// rle6_checker
// Port-level checks for the run-length alpha layer decoder.
// ----------------------------------------------------------------------------
module rle6_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_we,
  input logic [22:0] cfg_wdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // input side never stalls while the result slot can move
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
    else $error("input stalled with free result slot");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:30] == 2'b00))
    else $error("result padding not zero");

endmodule

bind rle_alpha6_layer_decoder rle6_checker u_rle6_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we        (cfg_we),
  .cfg_wdata     (cfg_wdata)
);

>>> dv/rle_alpha6_layer_decoder_checker.sv
// ----------------------------------------------------------------------------
// rle_alpha6_layer_decoder_checker
// Watches both streams and the config port of the alpha layer decoder, keeps
// its own decode state, and compares every alpha write with the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_alpha6_layer_decoder_checker
  import rle6_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] layer_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [21:0] pixel_index, [29:22] alpha_value
  input  logic        m_axis_tuser,   // [0] out_of_range
  input  logic        cfg_we,
  input  logic [22:0] cfg_wdata,      // [22:0] pixel_count
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          flagged
);

  // decode state as the block should hold it
  logic [RUN_W-1:0] run_left;
  logic [PIX_W-1:0] write_pos;
  logic [CNT_W-1:0] image_pixels;
  result_t          alpha_writes_due[$];

  // 6-bit alpha stretched to 8 bits, rounded down
  function automatic logic [ALPHA_W-1:0] widen_alpha(input logic [A6_W-1:0] a6);
    return ALPHA_W'((int'(a6) * 255) / 63);
  endfunction

  // one stream byte: either a literal alpha or a control byte
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic first);
    result_t          due;
    logic [A6_W-1:0]  a6;
    if (first) begin
      run_left  = '0;
      write_pos = '0;
    end
    if (run_left != '0) begin
      // clamp, invert, widen
      a6 = (b > BYTE_W'(ALPHA_MAX)) ? ALPHA_MAX : b[A6_W-1:0];
      due.pixel_index  = write_pos;
      due.alpha_value  = widen_alpha(ALPHA_MAX - a6);
      due.out_of_range = ({1'b0, write_pos} >= image_pixels);
      alpha_writes_due.push_back(due);
      write_pos = write_pos + 1'b1;
      run_left  = run_left - 1'b1;
    end else if (b > CTRL_MIN_NEG) begin
      // negative control byte other than 0x80 opens a literal run
      run_left = b[RUN_W-1:0];
    end else if (b != '0 && b < CTRL_MIN_NEG) begin
      // positive control byte skips pixels
      write_pos = write_pos + PIX_W'(b);
    end
  endtask

  // compare one alpha write transaction with the oldest prediction
  task automatic check_write();
    result_t due;
    if (alpha_writes_due.size() == 0) begin
      $error("alpha write at pixel %0d with nothing expected", m_axis_tdata[21:0]);
      mismatches++;
    end else begin
      due = alpha_writes_due.pop_front();
      if (m_axis_tdata[21:0] !== due.pixel_index) begin
        $error("pixel_index: expected %0d, got %0d", due.pixel_index, m_axis_tdata[21:0]);
        mismatches++;
      end
      if (m_axis_tdata[29:22] !== due.alpha_value) begin
        $error("alpha_value: expected %0d, got %0d", due.alpha_value, m_axis_tdata[29:22]);
        mismatches++;
      end
      if (m_axis_tuser !== due.out_of_range) begin
        $error("out_of_range: expected %0d, got %0d", due.out_of_range, m_axis_tuser);
        mismatches++;
      end
      checked++;
      if (due.out_of_range) flagged++;
    end
  endtask

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      run_left     = '0;
      write_pos    = '0;
      image_pixels = PIXEL_COUNT_RESET;
      alpha_writes_due.delete();
    end else begin
      if (cfg_we) image_pixels = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) check_write();
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
    end
    pending = alpha_writes_due.size();
  end

endmodule

>>> dv/rle_alpha6_layer_decoder_test.sv
// ----------------------------------------------------------------------------
// rle_alpha6_layer_decoder_test
// Drives run-length alpha layer streams into the decoder under random
// backpressure and several pixel counts; the checker predicts each write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_alpha6_layer_decoder_test;
  import rle6_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int GAP_MAX       = 13;

  // control byte values
  localparam logic [7:0] CTRL_NOP      = 8'h00;
  localparam logic [7:0] CTRL_SKIP_MAX = 8'h7F;
  localparam logic [7:0] RUN_FLAG      = 8'h80;

  // pixel count settings
  localparam logic [22:0] COUNT_ALL_ONES = 23'h7FFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [22:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int checked;
  int flagged;
  int cycles = 0;
  int bytes_sent = 0;
  int count_writes = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  rle_alpha6_layer_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  rle_alpha6_layer_decoder_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked),
    .flagged      (flagged)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes still due", cycles, pending);
      $display("rle_alpha6_layer_decoder_test: FAIL");
      $finish;
    end
  end

  // receiver: random stalls per transaction, one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // send one stream byte and wait for its transaction
  task automatic push_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // stop sending and let every due write come out
  task automatic wait_writes_done();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pixel_count(input logic [22:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_writes++;
  endtask

  // literal alpha, mostly in the 6-bit range, sometimes saturating
  function automatic logic [7:0] draw_alpha();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(64, 255));
    return 8'($urandom_range(0, 63));
  endfunction

  task automatic literal_run(input int len, input logic first);
    push_byte(RUN_FLAG | 8'(len), first);
    repeat (len) push_byte(draw_alpha(), 1'b0);
  endtask

  // mostly well-formed layers with random content, some noise and cut runs
  task automatic random_layers(input int n_bytes);
    int    base;
    int    pick;
    int    len;
    int    cut;
    logic  first;
    base = bytes_sent;
    while (bytes_sent - base < n_bytes) begin
      pick  = $urandom_range(0, 99);
      first = ($urandom_range(0, 7) == 0);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 12);
        literal_run(len, first);
      end else if (pick < 80) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
        push_byte(8'(len), first);
      end else if (pick < 88) begin
        push_byte($urandom_range(0, 1) ? CTRL_NOP : RUN_FLAG, first);
      end else if (pick < 94) begin
        // layer start cuts a literal run short
        len = $urandom_range(2, 20);
        cut = $urandom_range(0, len - 1);
        push_byte(RUN_FLAG | 8'(len), first);
        repeat (cut) push_byte(draw_alpha(), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_byte(8'($urandom_range(0, 255)), first);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no-op controls, skip extremes, saturation, cut run
    push_byte(CTRL_NOP, 1'b1);
    push_byte(RUN_FLAG, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h83, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h3F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(CTRL_SKIP_MAX, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h15, 1'b0);
    push_byte(8'h84, 1'b0);
    push_byte(8'h2A, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h3E, 1'b0);
    wait_writes_done();

    // empty image: every write is past the end
    write_pixel_count('0);
    random_layers(300);
    wait_writes_done();

    // one-pixel image, with a long receiver hold-off
    write_pixel_count(23'd1);
    hold_req = 1'b1;
    literal_run(100, 1'b1);
    random_layers(300);
    wait_writes_done();

    // small image with no idling on either side
    write_pixel_count(23'd40);
    quiet = 1'b1;
    random_layers(300);
    quiet = 1'b0;
    wait_writes_done();

    // random small image
    write_pixel_count(23'($urandom_range(0, 300)));
    random_layers(300);
    wait_writes_done();

    // all-ones count, then back to the full 2^22 count
    write_pixel_count(COUNT_ALL_ONES);
    random_layers(300);
    wait_writes_done();
    write_pixel_count(PIXEL_COUNT_RESET);
    random_layers(300);
    wait_writes_done();

    $display("sent %0d stream bytes over %0d pixel count settings, checked %0d alpha writes",
             bytes_sent, count_writes, checked);
    $display("%0d writes flagged past the image, with cut runs and long output stalls",
             flagged);
    if (mismatches == 0 && pending == 0) begin
      $display("rle_alpha6_layer_decoder_test: PASS");
    end else begin
      $display("rle_alpha6_layer_decoder_test: FAIL");
    end
    $finish;
  end

endmodule
